// ===== rtl/temperature_reading_qualifier_defines.svh =====
// Assertion macros for the temperature reading qualifier.
`ifndef TEMPERATURE_READING_QUALIFIER_DEFINES_SVH
`define TEMPERATURE_READING_QUALIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked with reset held off.
`define TRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define TRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/trq_pkg.sv =====
// Shared types, constants and the bus status decode of the temperature reading qualifier.
package trq_pkg;

    localparam int NUM_SENSORS   = 16;
    localparam int HISTORY_DEPTH = 4;
    localparam int ERROR_LIMIT   = 3;

    localparam int SENS_W = 4;
    localparam int BUS_W  = 4;
    localparam int ERR_W  = 4;
    localparam int TEMP_W = 16;
    localparam int OFFS_W = 16;
    localparam int RAW_W  = 13;
    localparam int PC_W   = 4;
    localparam int EC_W   = 8;

    localparam int SIDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int HIDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_N  = NUM_SENSORS * HISTORY_DEPTH;
    localparam int HADDR_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int SUM_W   = RAW_W + $clog2(HISTORY_DEPTH + 1) + 1;
    localparam int Y_W     = 22;

    // divide by constant: reciprocal multiply plus one correction step
    localparam int DIV_W  = 21;
    localparam int DIVR_W = 20;
    localparam int DIVD_W = 8;
    localparam int PROD_W = DIV_W + DIVR_W;
    localparam int AVG_N  = HISTORY_DEPTH + 1;
    localparam logic [DIVD_W-1:0] DIV_D_AVG = DIVD_W'(2 * AVG_N);
    localparam logic [DIVD_W-1:0] DIV_D_OFS = DIVD_W'(125);
    localparam logic [DIVR_W-1:0] DIV_R_AVG = DIVR_W'((64'd1 << DIV_W) / (2 * AVG_N));
    localparam logic [DIVR_W-1:0] DIV_R_OFS = DIVR_W'((64'd1 << DIV_W) / 125);

    localparam logic signed [TEMP_W-1:0] RANGE_LOW    = 16'shFC90;
    localparam logic signed [TEMP_W-1:0] RANGE_HIGH   = 16'sh07D0;
    localparam logic signed [TEMP_W-1:0] POR_VALUE    = 16'sh0550;
    localparam logic signed [TEMP_W-1:0] PULLUP_VALUE = 16'sh07FF;
    localparam logic [PC_W-1:0]          POR_MAX      = 4'd10;
    localparam logic [EC_W-1:0]          EC_MAX       = EC_W'(ERROR_LIMIT - 1);

    localparam logic [BUS_W-1:0] BUS_OK           = 4'd0;
    localparam logic [BUS_W-1:0] BUS_NO_BUS       = 4'd1;
    localparam logic [BUS_W-1:0] BUS_CONV_NO_PRES = 4'd2;
    localparam logic [BUS_W-1:0] BUS_CONV_FAIL    = 4'd3;
    localparam logic [BUS_W-1:0] BUS_ZEROS        = 4'd4;
    localparam logic [BUS_W-1:0] BUS_ONES         = 4'd5;
    localparam logic [BUS_W-1:0] BUS_CRC          = 4'd6;
    localparam logic [BUS_W-1:0] BUS_FORMAT       = 4'd7;
    localparam logic [BUS_W-1:0] BUS_NO_PRES      = 4'd8;

    localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [ERR_W-1:0] ERR_NO_BUS    = 4'd1;
    localparam logic [ERR_W-1:0] ERR_CONV_FAIL = 4'd2;
    localparam logic [ERR_W-1:0] ERR_ZEROS     = 4'd3;
    localparam logic [ERR_W-1:0] ERR_ONES      = 4'd4;
    localparam logic [ERR_W-1:0] ERR_CRC       = 4'd5;
    localparam logic [ERR_W-1:0] ERR_FORMAT    = 4'd6;
    localparam logic [ERR_W-1:0] ERR_NO_PRES   = 4'd7;
    localparam logic [ERR_W-1:0] ERR_POR       = 4'd8;
    localparam logic [ERR_W-1:0] ERR_PULLUP    = 4'd9;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 4'd10;
    localparam logic [ERR_W-1:0] ERR_OTHER     = 4'd11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SENS_W-1:0]        sensor;
        logic                     ignore;
        logic [ERR_W-1:0]         err;
        logic                     por;
        logic signed [RAW_W-1:0]  raw;
        logic signed [OFFS_W-1:0] offset;
    } qitem_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [ERR_W-1:0] bus_code(input logic [BUS_W-1:0] bus);
        logic [ERR_W-1:0] code;
        case (bus)
            BUS_OK:           code = ERR_NONE;
            BUS_NO_BUS:       code = ERR_NO_BUS;
            BUS_CONV_NO_PRES: code = ERR_NO_PRES;
            BUS_CONV_FAIL:    code = ERR_CONV_FAIL;
            BUS_ZEROS:        code = ERR_ZEROS;
            BUS_ONES:         code = ERR_ONES;
            BUS_CRC:          code = ERR_CRC;
            BUS_FORMAT:       code = ERR_FORMAT;
            BUS_NO_PRES:      code = ERR_NO_PRES;
            default:          code = ERR_OTHER;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/temperature_reading_qualifier.sv =====
// Top level of the temperature reading qualifier: front end, item queue, back end.
// Each item is one sensor reading; exactly one result item comes back per input item, in order.
// The front end classifies an item in the cycle it is taken and drops it into a two-entry
// queue, so input items are taken back to back while the queue has room, even while a
// result waits at the output. The back end works on one item at a time: an item that ends
// in an error, a skipped power-on value or an unknown sensor goes from evaluation straight
// to the result; an item that refreshes the temperature first walks the history memory,
// one entry per cycle on its single read port, and makes two passes through the shared
// reciprocal-multiply constant divider. Either kind then waits for a free output slot.
// The history memory needs no clearing after reset: a sensor's history is seeded on its
// first valid reading.
`include "temperature_reading_qualifier_defines.svh"

module temperature_reading_qualifier import trq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SENS_W-1:0]        s_sensor,
    input  logic [BUS_W-1:0]         s_bus_status,
    input  logic signed [TEMP_W-1:0] s_raw_temp,
    input  logic signed [OFFS_W-1:0] s_offset_milli,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SENS_W-1:0]        m_sensor_out,
    output logic [ERR_W-1:0]         m_fault_code,
    output logic signed [TEMP_W-1:0] m_temperature,
    output logic                     m_valid_res,
    output logic                     m_updated
);

    q_status_t q_status;
    qitem_t    q_push_item;
    qitem_t    q_head;
    logic      q_push;
    logic      q_pop;

    trq_front u_front (
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor       (s_sensor),
        .s_bus_status   (s_bus_status),
        .s_raw_temp     (s_raw_temp),
        .s_offset_milli (s_offset_milli),
        .q_full         (q_status.full),
        .q_push         (q_push),
        .q_item         (q_push_item)
    );

    trq_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_push      (q_push),
        .q_push_item (q_push_item),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .q_status    (q_status)
    );

    trq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_status.empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sensor_out  (m_sensor_out),
        .m_fault_code  (m_fault_code),
        .m_temperature (m_temperature),
        .m_valid_res   (m_valid_res),
        .m_updated     (m_updated)
    );

    `TRQ_ASSERT(a_upd_clean, aclk, aresetn,
        m_valid && m_updated |-> (m_fault_code == ERR_NONE) && m_valid_res,
        "refreshed item carries an error or invalid flag")
    `TRQ_ASSERT(a_q_state, aclk, aresetn, !(q_status.full && q_status.empty),
        "queue full and empty at once")
    `TRQ_ASSERT(a_q_no_ovf, aclk, aresetn, q_push |-> !q_status.full || q_pop,
        "item pushed into full queue")
    `TRQ_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_valid,
        "result valid right after reset")

endmodule

// ===== rtl/trq_front.sv =====
// Front end: takes input items and classifies bus status, range and power-on value.
module trq_front import trq_pkg::*; (
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SENS_W-1:0]        s_sensor,
    input  logic [BUS_W-1:0]         s_bus_status,
    input  logic signed [TEMP_W-1:0] s_raw_temp,
    input  logic signed [OFFS_W-1:0] s_offset_milli,
    input  logic                     q_full,
    output logic                     q_push,
    output qitem_t                   q_item
);

    logic in_range;
    logic bus_ok;
    logic ignore_item;

    assign bus_ok   = (s_bus_status == BUS_OK);
    assign in_range = (s_raw_temp >= RANGE_LOW) && (s_raw_temp <= RANGE_HIGH);
    assign s_ready  = aresetn && !q_full;
    assign q_push   = s_valid && s_ready;

    always_comb begin
        q_item        = '0;
        q_item.sensor = s_sensor;
        q_item.ignore = ignore_item;
        q_item.raw    = RAW_W'(s_raw_temp);
        q_item.offset = s_offset_milli;
        if (!bus_ok) begin
            q_item.err = bus_code(s_bus_status);
        end else if (!in_range) begin
            q_item.err = (s_raw_temp == PULLUP_VALUE) ? ERR_PULLUP : ERR_RANGE;
        end else begin
            q_item.err = ERR_NONE;
            q_item.por = (s_raw_temp == POR_VALUE);
        end
    end

    // sensor index beyond the table
    always_comb begin
        ignore_item = (32'(s_sensor) >= NUM_SENSORS);
    end

endmodule

// ===== rtl/trq_queue.sv =====
// Short item queue between front end and back end.
module trq_queue import trq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_push,
    input  qitem_t    q_push_item,
    input  logic      q_pop,
    output qitem_t    q_head,
    output q_status_t q_status
);

    qitem_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_head         = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (q_push) begin
            entry_reg[wr_ptr_reg] <= q_push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (q_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (q_push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !q_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/trq_back.sv =====
// Back end: per-sensor state, history walk, averaging, offset and the result register.
module trq_back import trq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  qitem_t                   q_head,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SENS_W-1:0]        m_sensor_out,
    output logic [ERR_W-1:0]         m_fault_code,
    output logic signed [TEMP_W-1:0] m_temperature,
    output logic                     m_valid_res,
    output logic                     m_updated
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_WALK, S_PREP, S_MUL, S_PROD, S_FIX, S_OFFS, S_DONE
    } state_t;

    state_t                   state_reg;
    qitem_t                   item_reg;

    logic                     vf_reg [NUM_SENSORS];
    logic [PC_W-1:0]          pc_reg [NUM_SENSORS];
    logic [EC_W-1:0]          ec_reg [NUM_SENSORS];
    logic signed [TEMP_W-1:0] lv_reg [NUM_SENSORS];

    logic signed [RAW_W-1:0]  hist_mem [HIST_N];
    logic signed [RAW_W-1:0]  hist_rdata_reg;

    logic [ERR_W-1:0]         res_err_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic                     res_vf_reg;
    logic                     res_upd_reg;
    logic [PC_W-1:0]          new_pc_reg;
    logic [EC_W-1:0]          new_ec_reg;

    logic [HIDX_W-1:0]        idx_reg;
    logic signed [RAW_W-1:0]  carry_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [RAW_W-1:0]  avg_reg;
    logic signed [Y_W-1:0]    y_reg;

    logic                     div_sel_reg;
    logic                     div_neg_reg;
    logic [DIV_W-1:0]         div_x_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DIV_W-1:0]         q0_reg;
    logic [DIV_W-1:0]         qd_reg;

    logic                     m_valid_reg;
    logic [SENS_W-1:0]        m_sensor_reg;
    logic [ERR_W-1:0]         m_err_reg;
    logic signed [TEMP_W-1:0] m_temp_reg;
    logic                     m_vres_reg;
    logic                     m_upd_reg;

    logic [SIDX_W-1:0]        sidx;
    logic                     cur_vf;
    logic [PC_W-1:0]          cur_pc;
    logic [EC_W-1:0]          cur_ec;
    logic                     por_stuck;
    logic                     por_first;
    logic                     do_update;
    logic [ERR_W-1:0]         err_eval;
    logic [PC_W-1:0]          pc_eval;
    logic [EC_W-1:0]          ec_eval;
    logic                     vf_eval;

    logic [HADDR_W-1:0]       base;
    logic [HIDX_W-1:0]        rd_idx;
    logic [HADDR_W-1:0]       rd_addr;
    logic [HADDR_W-1:0]       wr_addr;
    logic                     hist_we;
    logic signed [RAW_W-1:0]  walk_data;
    logic                     walk_last;

    logic [SUM_W-1:0]         sum_mag;
    logic [Y_W-1:0]           y_mag;
    logic signed [Y_W-1:0]    y_calc;
    logic [DIVD_W-1:0]        div_d;
    logic [DIVR_W-1:0]        div_r;
    logic [DIV_W-1:0]         div_rem;
    logic [DIV_W-1:0]         q_fix;
    logic signed [DIV_W:0]    q_signed;
    logic                     out_free;

    assign sidx   = SIDX_W'(item_reg.sensor);
    assign cur_vf = vf_reg[sidx];
    assign cur_pc = pc_reg[sidx];
    assign cur_ec = ec_reg[sidx];

    // classification against per-sensor state
    always_comb begin
        por_stuck = item_reg.por && (cur_pc >= POR_MAX);
        por_first = item_reg.por && (cur_pc == '0);
        do_update = (item_reg.err == ERR_NONE) && !por_stuck && !por_first;
        err_eval  = (item_reg.err != ERR_NONE) ? item_reg.err
                  : (por_stuck ? ERR_POR : ERR_NONE);
        if (item_reg.por && !por_stuck) begin
            pc_eval = cur_pc + 1'b1;
        end else if (item_reg.por) begin
            pc_eval = cur_pc;
        end else begin
            pc_eval = '0;
        end
        ec_eval = cur_ec;
        vf_eval = cur_vf;
        if (err_eval != ERR_NONE) begin
            if (cur_ec < EC_MAX) begin
                ec_eval = cur_ec + 1'b1;
            end else begin
                vf_eval = 1'b0;
            end
        end else if (do_update) begin
            ec_eval = '0;
            vf_eval = 1'b1;
        end
    end

    // history addressing: one entry per cycle, read data registered
    always_comb begin
        base      = HADDR_W'(32'(sidx) * HISTORY_DEPTH);
        walk_last = (idx_reg == HIDX_W'(HISTORY_DEPTH - 1));
        if (state_reg == S_EVAL || walk_last) begin
            rd_idx = '0;
        end else begin
            rd_idx = idx_reg + 1'b1;
        end
        rd_addr   = base + HADDR_W'(rd_idx);
        wr_addr   = base + HADDR_W'(idx_reg);
        hist_we   = (state_reg == S_WALK);
        walk_data = cur_vf ? hist_rdata_reg : item_reg.raw;
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wr_addr] <= carry_reg;
        end
        hist_rdata_reg <= hist_mem[rd_addr];
    end

    // divider operands and correction
    always_comb begin
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        y_mag    = y_reg[Y_W-1] ? Y_W'(-y_reg) : Y_W'(y_reg);
        // avg*125 + 2*offset
        y_calc   = (Y_W'(avg_reg) <<< 7) - (Y_W'(avg_reg) <<< 2) + Y_W'(avg_reg)
                 + (Y_W'(item_reg.offset) <<< 1);
        div_d    = div_sel_reg ? DIV_D_OFS : DIV_D_AVG;
        div_r    = div_sel_reg ? DIV_R_OFS : DIV_R_AVG;
        div_rem  = div_x_reg - qd_reg;
        q_fix    = q0_reg + DIV_W'(div_rem >= DIV_W'(div_d));
        q_signed = div_neg_reg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    end

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                vf_reg[i] <= 1'b0;
                pc_reg[i] <= '0;
                ec_reg[i] <= '0;
                lv_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        item_reg  <= q_head;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    res_err_reg  <= item_reg.ignore ? ERR_NONE : err_eval;
                    res_vf_reg   <= !item_reg.ignore && vf_eval;
                    res_upd_reg  <= !item_reg.ignore && do_update;
                    res_temp_reg <= item_reg.ignore ? '0 : lv_reg[sidx];
                    new_pc_reg   <= pc_eval;
                    new_ec_reg   <= ec_eval;
                    idx_reg      <= '0;
                    carry_reg    <= item_reg.raw;
                    sum_reg      <= SUM_W'(item_reg.raw);
                    div_sel_reg  <= 1'b0;
                    if (!item_reg.ignore && do_update) begin
                        state_reg <= S_WALK;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_WALK: begin
                    sum_reg   <= sum_reg + SUM_W'(walk_data);
                    carry_reg <= walk_data;
                    idx_reg   <= idx_reg + 1'b1;
                    if (walk_last) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (div_sel_reg) begin
                        div_x_reg   <= DIV_W'(y_mag);
                        div_neg_reg <= y_reg[Y_W-1];
                    end else begin
                        div_x_reg   <= DIV_W'({sum_mag, 1'b0}) + DIV_W'(AVG_N);
                        div_neg_reg <= sum_reg[SUM_W-1];
                    end
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= PROD_W'(div_x_reg) * PROD_W'(div_r);
                    state_reg <= S_PROD;
                end
                S_PROD: begin
                    q0_reg    <= DIV_W'(prod_reg[PROD_W-1:DIV_W]);
                    qd_reg    <= DIV_W'(prod_reg[PROD_W-1:DIV_W]) * DIV_W'(div_d);
                    state_reg <= S_FIX;
                end
                S_FIX: begin
                    if (div_sel_reg) begin
                        res_temp_reg <= TEMP_W'(q_signed);
                        state_reg    <= S_DONE;
                    end else begin
                        avg_reg     <= RAW_W'(q_signed);
                        div_sel_reg <= 1'b1;
                        state_reg   <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    y_reg     <= y_calc;
                    state_reg <= S_PREP;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sensor_reg <= item_reg.sensor;
                        m_err_reg    <= res_err_reg;
                        m_temp_reg   <= res_temp_reg;
                        m_vres_reg   <= res_vf_reg;
                        m_upd_reg    <= res_upd_reg;
                        if (!item_reg.ignore) begin
                            vf_reg[sidx] <= res_vf_reg;
                            pc_reg[sidx] <= new_pc_reg;
                            ec_reg[sidx] <= new_ec_reg;
                            if (res_upd_reg) begin
                                lv_reg[sidx] <= res_temp_reg;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sensor_out  = m_sensor_reg;
    assign m_fault_code  = m_err_reg;
    assign m_temperature = m_temp_reg;
    assign m_valid_res   = m_vres_reg;
    assign m_updated     = m_upd_reg;

endmodule
